### rtl/fccm_pkg.sv
`default_nettype none

package fccm_pkg;

  // Table geometry
  localparam int          MAX_CLUSTERS_DEF = 4096;
  localparam int          TABLE_LIMIT      = 4096;
  localparam int          ENTRY_W          = 16;
  localparam logic [12:0] CLUSTERS_RESET   = 13'd4096;
  localparam logic [12:0] DIR_CLUSTER      = 13'd32;
  localparam logic [12:0] FIRST_DATA       = 13'd33;

  // Entry codes
  localparam logic [15:0] CODE_FREE  = 16'd1;
  localparam logic [15:0] CODE_END   = 16'd2;
  localparam logic [15:0] CODE_TABLE = 16'd3;
  localparam logic [15:0] CODE_DIR   = 16'd4;

  // Operation kinds
  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_FORMAT = 3'd1;
  localparam logic [2:0] KIND_CHECK  = 3'd2;
  localparam logic [2:0] KIND_COUNT  = 3'd3;
  localparam logic [2:0] KIND_ALLOC  = 3'd4;
  localparam logic [2:0] KIND_EXTEND = 3'd5;
  localparam logic [2:0] KIND_FREE   = 3'd6;

  // Result status
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SPACE    = 2'd1;
  localparam logic [1:0] ST_CHAIN_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] cluster;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] new_cluster;
    logic [12:0] free_clusters;
    logic        formatted;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/fccm_ram.sv
`default_nettype none

module fccm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/fat_cluster_chain_manager_top.sv
`default_nettype none

// File allocation table cluster chain manager.
// Input: an item (kind, cluster, value) is taken when start is high and busy
// is low. Output: one result item per input, shown for one cycle with
// out_valid; the receiver cannot stall, so every result is taken at once.
// Config: APB register clusters_in_use at byte address 0 (reset 4096); write
// it only while busy is low and no result is pending.
// The table lives in one RAM (one write, one registered read port); the
// operations use it as follows (n = table size):
//   load entry, unused kind : result in the next cycle, busy stays low
//   check formatted         : reads entries 0..32
//   format                  : writes entries 0..max(n,33)-1, one write per cycle
//   count free              : reads entries 0..n-1, one read per cycle
//   allocate                : scan from entry 33 to the first free entry, then write end code
//   extend                  : tail read + allocate scan + 1 more write
//   free chain              : each link read to check, then each link read and freed
// Reset (rst_n low, synchronous) returns to idle and sets the register back
// to 4096; table contents are undefined until formatted or loaded.
module fat_cluster_chain_manager_top #(
  parameter int MAX_CLUSTERS = fccm_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // item channel
  input  wire logic                start,
  output logic                     busy,
  input  wire fccm_pkg::in_item_t  in_item,
  // result channel
  output logic                     out_valid,
  output fccm_pkg::out_item_t      out_item,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [0:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int DEPTH = (MAX_CLUSTERS > fccm_pkg::TABLE_LIMIT) ?
                         fccm_pkg::TABLE_LIMIT : MAX_CLUSTERS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [12:0] DEPTH13 = 13'(DEPTH);
  localparam logic [0:0]  ADDR_CLUSTERS = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_SCAN,
    S_TAIL_EV,
    S_WR_TAIL,
    S_WR_NEW,
    S_CV_RD,
    S_CV_EV,
    S_FR_RD,
    S_FR_EV
  } state_t;

  // Registers
  state_t              state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [11:0]         cl_r, cl_nxt;
  logic [12:0]         scan_addr_r, scan_addr_nxt;
  logic [12:0]         scan_end_r, scan_end_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [12:0]         pend_idx_r, pend_idx_nxt;
  logic [12:0]         cnt_r, cnt_nxt;
  logic                fmt_r, fmt_nxt;
  logic [11:0]         f_r, f_nxt;
  logic [11:0]         p_r, p_nxt;
  logic [12:0]         steps_r, steps_nxt;
  logic                out_valid_r, out_valid_nxt;
  fccm_pkg::out_item_t out_item_r, out_item_nxt;
  logic [12:0]         clusters_r;

  // RAM port
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [15:0]         mem_wdata, rd_data;

  logic                accept, cfg_wr;
  logic [12:0]         n_size;
  logic                cl_in_data, d_in_data, d_is_free, scan_issue;
  logic [12:0]         steps_inc;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CLUSTERS);
  assign prdata = (paddr == ADDR_CLUSTERS) ? {19'd0, clusters_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clusters_r <= fccm_pkg::CLUSTERS_RESET;
    end else if (cfg_wr) begin
      clusters_r <= pwdata[12:0];
    end
  end

  // Effective table size
  assign n_size = (clusters_r > DEPTH13) ? DEPTH13 : clusters_r;

  assign accept     = start && !busy;
  assign cl_in_data = ({1'b0, in_item.cluster} >= fccm_pkg::FIRST_DATA) &&
                      ({1'b0, in_item.cluster} < n_size);
  assign d_in_data  = (rd_data >= 16'(fccm_pkg::FIRST_DATA)) &&
                      (rd_data < {3'd0, n_size});
  assign d_is_free  = (rd_data == fccm_pkg::CODE_FREE);
  assign scan_issue = (scan_addr_r < scan_end_r);
  assign steps_inc  = steps_r + 13'd1;

  fccm_ram #(
    .WIDTH (fccm_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Sequencer: each state does at most one read or one write
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cl_nxt        = cl_r;
    scan_addr_nxt = scan_addr_r;
    scan_end_nxt  = scan_end_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    cnt_nxt       = cnt_r;
    fmt_nxt       = fmt_r;
    f_nxt         = f_r;
    p_nxt         = p_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_item.kind;
          cl_nxt       = in_item.cluster;
          out_item_nxt = '0;
          unique case (in_item.kind)
            fccm_pkg::KIND_LOAD: begin
              mem_we        = ({1'b0, in_item.cluster} < DEPTH13);
              mem_waddr     = in_item.cluster[AW-1:0];
              mem_wdata     = in_item.value;
              out_valid_nxt = 1'b1;
            end
            fccm_pkg::KIND_FORMAT: begin
              scan_addr_nxt = '0;
              scan_end_nxt  = (n_size < fccm_pkg::FIRST_DATA) ?
                              fccm_pkg::FIRST_DATA : n_size;
              state_nxt     = S_FMT;
            end
            fccm_pkg::KIND_CHECK: begin
              scan_addr_nxt = '0;
              scan_end_nxt  = fccm_pkg::FIRST_DATA;
              fmt_nxt       = 1'b1;
              state_nxt     = S_SCAN;
            end
            fccm_pkg::KIND_COUNT: begin
              scan_addr_nxt = '0;
              scan_end_nxt  = n_size;
              cnt_nxt       = '0;
              state_nxt     = S_SCAN;
            end
            fccm_pkg::KIND_ALLOC: begin
              scan_addr_nxt = fccm_pkg::FIRST_DATA;
              scan_end_nxt  = n_size;
              state_nxt     = S_SCAN;
            end
            fccm_pkg::KIND_EXTEND: begin
              if (cl_in_data) begin
                mem_re    = 1'b1;
                mem_raddr = in_item.cluster[AW-1:0];
                state_nxt = S_TAIL_EV;
              end else begin
                out_item_nxt.status = fccm_pkg::ST_CHAIN_ERROR;
                out_valid_nxt       = 1'b1;
              end
            end
            fccm_pkg::KIND_FREE: begin
              if (cl_in_data) begin
                mem_re    = 1'b1;
                mem_raddr = in_item.cluster[AW-1:0];
                p_nxt     = in_item.cluster;
                steps_nxt = '0;
                state_nxt = S_CV_EV;
              end else begin
                out_item_nxt.status = fccm_pkg::ST_CHAIN_ERROR;
                out_valid_nxt       = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Format sweep: one entry written per cycle
      S_FMT: begin
        if (scan_issue) begin
          mem_we    = 1'b1;
          mem_waddr = scan_addr_r[AW-1:0];
          if (scan_addr_r < fccm_pkg::DIR_CLUSTER) begin
            mem_wdata = fccm_pkg::CODE_TABLE;
          end else if (scan_addr_r == fccm_pkg::DIR_CLUSTER) begin
            mem_wdata = fccm_pkg::CODE_DIR;
          end else begin
            mem_wdata = fccm_pkg::CODE_FREE;
          end
          scan_addr_nxt = scan_addr_r + 13'd1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Read sweep: address issued each cycle, data checked in the next cycle
      S_SCAN: begin
        if (pend_vld_r && d_is_free &&
            (op_r == fccm_pkg::KIND_ALLOC || op_r == fccm_pkg::KIND_EXTEND)) begin
          f_nxt     = pend_idx_r[11:0];
          state_nxt = (op_r == fccm_pkg::KIND_EXTEND) ? S_WR_TAIL : S_WR_NEW;
        end else begin
          if (pend_vld_r) begin
            if (op_r == fccm_pkg::KIND_COUNT && d_is_free) begin
              cnt_nxt = cnt_r + 13'd1;
            end
            if (op_r == fccm_pkg::KIND_CHECK) begin
              if (pend_idx_r < fccm_pkg::DIR_CLUSTER) begin
                if (rd_data != fccm_pkg::CODE_TABLE) begin
                  fmt_nxt = 1'b0;
                end
              end else if (rd_data != fccm_pkg::CODE_DIR) begin
                fmt_nxt = 1'b0;
              end
            end
          end
          if (scan_issue) begin
            mem_re        = 1'b1;
            mem_raddr     = scan_addr_r[AW-1:0];
            scan_addr_nxt = scan_addr_r + 13'd1;
            pend_vld_nxt  = 1'b1;
            pend_idx_nxt  = scan_addr_r;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            case (op_r)
              fccm_pkg::KIND_COUNT: out_item_nxt.free_clusters = cnt_nxt;
              fccm_pkg::KIND_CHECK: out_item_nxt.formatted     = fmt_nxt;
              default:              out_item_nxt.status        = fccm_pkg::ST_NO_SPACE;
            endcase
          end
        end
      end

      // Tail of extend must hold end of chain
      S_TAIL_EV: begin
        if (rd_data != fccm_pkg::CODE_END) begin
          out_item_nxt.status = fccm_pkg::ST_CHAIN_ERROR;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          scan_addr_nxt = fccm_pkg::FIRST_DATA;
          scan_end_nxt  = n_size;
          state_nxt     = S_SCAN;
        end
      end

      // Link old tail to the new cluster
      S_WR_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = cl_r[AW-1:0];
        mem_wdata = {4'd0, f_r};
        state_nxt = S_WR_NEW;
      end

      // New cluster ends the chain
      S_WR_NEW: begin
        mem_we                   = 1'b1;
        mem_waddr                = f_r[AW-1:0];
        mem_wdata                = fccm_pkg::CODE_END;
        out_item_nxt.new_cluster = f_r;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end

      // Chain check: follow links, bounded by n-33 steps
      S_CV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = p_r[AW-1:0];
        state_nxt = S_CV_EV;
      end

      S_CV_EV: begin
        if (rd_data == fccm_pkg::CODE_END) begin
          p_nxt     = cl_r;
          state_nxt = S_FR_RD;
        end else if (!d_in_data ||
                     (steps_inc >= (n_size - fccm_pkg::FIRST_DATA))) begin
          out_item_nxt.status = fccm_pkg::ST_CHAIN_ERROR;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          steps_nxt = steps_inc;
          p_nxt     = rd_data[11:0];
          state_nxt = S_CV_RD;
        end
      end

      // Free pass over a chain already known to be sound
      S_FR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = p_r[AW-1:0];
        state_nxt = S_FR_EV;
      end

      S_FR_EV: begin
        mem_we    = 1'b1;
        mem_waddr = p_r[AW-1:0];
        mem_wdata = fccm_pkg::CODE_FREE;
        if (rd_data == fccm_pkg::CODE_END) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          p_nxt     = rd_data[11:0];
          state_nxt = S_FR_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    cl_r        <= cl_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_end_r  <= scan_end_nxt;
    pend_idx_r  <= pend_idx_nxt;
    cnt_r       <= cnt_nxt;
    fmt_r       <= fmt_nxt;
    f_r         <= f_nxt;
    p_r         <= p_nxt;
    steps_r     <= steps_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // A result only follows an accepted item or finished work
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without an item in flight");

  // The sequencer never reads and writes one entry in the same cycle
  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of one entry in one cycle");

  // Pending scan data always belongs to the scanned range
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (pend_idx_r < scan_end_r) && (state_r == S_SCAN))
    else $error("scan data outside its range");

  // Failed operations report no new cluster
  a_fail_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != fccm_pkg::ST_OK) |-> out_item.new_cluster == 12'd0)
    else $error("new cluster reported with an error");
`endif

endmodule

`default_nettype wire
